[src/wthq_pkg.sv]
`default_nettype none
package wthq_pkg;

    localparam int unsigned OP_W = 2;
    localparam int unsigned STATUS_W = 2;

    typedef enum logic [1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2,
        OP_GET  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_BADINDEX = 2'd3
    } status_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic latch_in;     // capture the input item, start an operation
        logic rd_slot;      // issue memory read at the slot pointer
        logic rd_left;      // issue memory read at left child
        logic rd_right;     // issue memory read at right child
        logic rd_parent;    // issue memory read at parent
        logic cap_slot;     // capture read data as the moving entry
        logic cap_left;     // capture read data as left child
        logic cap_right;    // capture read data as right child
        logic cap_parent;   // capture read data as parent
        logic cap_result;   // capture read data for the result
        logic wr_moving;    // write moving entry at slot pointer
        logic wr_pick;      // write chosen child at pointer, advance down
        logic wr_parent;    // write parent at pointer, move up
        logic push_setup;   // set pointer to count for push, bump count/seq
        logic pop_setup;    // take root handle, drop count, pointer to last
        logic root_ptr;     // pointer to root
        logic out_load;     // load output register
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        op_t  op;
        logic full;         // push would overflow
        logic empty;        // count is zero
        logic bad_index;    // get index outside the heap
        logic has_left;     // left child inside the heap
        logic has_right;    // right child inside the heap
        logic at_top;       // pointer at root
        logic moving_first; // moving entry orders before parent
        logic last_gone;    // pop left heap empty
    } stat_t;

endpackage
`default_nettype wire

[src/wraparound_timer_heap_queue_unit.sv]
// Channel   Dir  Fields (low bit up)
// s_axis    in   tdata: operation[1:0] deadline[31:2] payload[63:32] slot_index[69:64]
// m_axis    out  tdata: status[1:0] handle_out[33:2] time_out[63:34] occupancy[70:64]
// cfg       in   capacity[6:0]
//
// One item at a time, on one memory port with registered read data.
// Push climbs level by level (read parent, capture, compare). Pop walks down
// to a leaf level by level (read left child, capture it and read right child,
// capture right child, write the chosen child), writes the moving entry at
// the leaf and then climbs back up the same way as push.
// Reset zeroes count and sequence and sets capacity to 64; heap memory is not
// cleared. The result holds on m_axis until taken; s_axis is not ready meanwhile.
`default_nettype none
module wraparound_timer_heap_queue_unit #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,  // operation, deadline, payload, slot_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [71:0] m_axis_tdata,  // status, handle_out, time_out, occupancy
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [6:0]  cfg_data
);

    wthq_pkg::cmd_t  cmd;
    wthq_pkg::stat_t stat;
    logic [1:0]  st;
    logic [31:0] ho;
    logic [29:0] to;
    logic [$clog2(DEPTH+1)-1:0] cnt;

    assign cfg_ready = 1'b1;

    wthq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat)
    );

    wthq_dp #(.DEPTH(DEPTH)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .in_op      (s_axis_tdata[1:0]),
        .in_time    (s_axis_tdata[31:2]),
        .in_handle  (s_axis_tdata[63:32]),
        .in_index   (s_axis_tdata[69:64]),
        .out_status (st),
        .out_handle (ho),
        .out_time   (to),
        .out_count  (cnt)
    );

    assign m_axis_tdata = {1'b0, 7'(cnt), to, ho, st};

endmodule
`default_nettype wire

[src/wthq_ram.sv]
`default_nettype none
module wthq_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

[src/wthq_ctrl.sv]
`default_nettype none
module wthq_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output wthq_pkg::cmd_t      cmd,
    input  wire wthq_pkg::stat_t stat
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b000000000001,
        S_DISPATCH= 12'b000000000010,
        S_DN_RDL  = 12'b000000000100,
        S_DN_RDR  = 12'b000000001000,
        S_DN_CAPR = 12'b000000010000,
        S_DN_STEP = 12'b000000100000,
        S_UP_CHK  = 12'b000001000000,
        S_UP_WAIT = 12'b000010000000,
        S_UP_CMP  = 12'b000100000000,
        S_RD_CAP  = 12'b001000000000,
        S_DONE    = 12'b010000000000,
        S_OUT     = 12'b100000000000
    } state_t;

    typedef enum logic {
        K_SLOT   = 1'b0,
        K_RESULT = 1'b1
    } rdkind_t;

    state_t  state_reg, state_next;
    rdkind_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= K_SLOT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);

    // Sequence each operation; output register holds result until taken
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        cmd        = '0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (stat.op == wthq_pkg::OP_PUSH)
                begin
                    if (stat.full)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        // moving entry already holds the new item
                        cmd.push_setup = 1'b1;
                        state_next     = S_UP_CHK;
                    end
                end
                else if (stat.op == wthq_pkg::OP_POP)
                begin
                    if (stat.empty)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.pop_setup = 1'b1;
                        cmd.rd_slot   = 1'b1;
                        kind_next     = K_SLOT;
                        state_next    = S_RD_CAP;
                    end
                end
                else
                begin
                    if ((stat.op == wthq_pkg::OP_PEEK && stat.empty)
                        || (stat.op == wthq_pkg::OP_GET && stat.bad_index))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd.rd_slot = 1'b1;
                        kind_next   = K_RESULT;
                        state_next  = S_RD_CAP;
                    end
                end
            end
            S_RD_CAP:
            begin
                unique case (kind_reg)
                    K_RESULT:
                    begin
                        cmd.cap_result = 1'b1;
                        state_next     = S_DONE;
                    end
                    K_SLOT:
                    begin
                        // last entry captured; walk down from root
                        cmd.cap_slot = 1'b1;
                        cmd.root_ptr = 1'b1;
                        state_next   = S_DN_RDL;
                    end
                endcase
            end
            S_DN_RDL:
            begin
                if (stat.last_gone)
                begin
                    state_next = S_DONE;
                end
                else if (stat.has_left)
                begin
                    cmd.rd_left = 1'b1;
                    state_next  = S_DN_RDR;
                end
                else
                begin
                    cmd.wr_moving = 1'b1;
                    state_next    = S_UP_CHK;
                end
            end
            S_DN_RDR:
            begin
                // left child data is on the read port now
                cmd.cap_left = 1'b1;
                cmd.rd_right = 1'b1;
                state_next   = S_DN_CAPR;
            end
            S_DN_CAPR:
            begin
                cmd.cap_right = stat.has_right;
                state_next    = S_DN_STEP;
            end
            S_DN_STEP:
            begin
                cmd.wr_pick = 1'b1;
                state_next  = S_DN_RDL;
            end
            S_UP_CHK:
            begin
                if (stat.at_top)
                begin
                    cmd.wr_moving = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    cmd.rd_parent = 1'b1;
                    state_next    = S_UP_WAIT;
                end
            end
            S_UP_WAIT:
            begin
                cmd.cap_parent = 1'b1;
                state_next     = S_UP_CMP;
            end
            S_UP_CMP:
            begin
                if (stat.moving_first)
                begin
                    cmd.wr_parent = 1'b1;
                    state_next    = S_UP_CHK;
                end
                else
                begin
                    cmd.wr_moving = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                cmd.out_load = 1'b1;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[src/wthq_dp.sv]
`default_nettype none
module wthq_dp #(
    parameter int unsigned DEPTH       = 64,
    parameter int unsigned TIME_BITS   = 30,
    parameter int unsigned SEQ_BITS    = 32,
    parameter int unsigned HANDLE_BITS = 32
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire wthq_pkg::cmd_t             cmd,
    output wthq_pkg::stat_t                 stat,
    input  wire logic                       cfg_we,
    input  wire logic [6:0]                 cfg_data,
    input  wire logic [1:0]                 in_op,
    input  wire logic [TIME_BITS-1:0]       in_time,
    input  wire logic [HANDLE_BITS-1:0]     in_handle,
    input  wire logic [5:0]                 in_index,
    output logic      [1:0]                 out_status,
    output logic      [HANDLE_BITS-1:0]     out_handle,
    output logic      [TIME_BITS-1:0]       out_time,
    output logic      [$clog2(DEPTH+1)-1:0] out_count
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned EW = TIME_BITS + SEQ_BITS + HANDLE_BITS;
    localparam logic [TIME_BITS-1:0] HALF = TIME_BITS'(1) << (TIME_BITS - 1);

    typedef struct packed {
        logic [TIME_BITS-1:0]   t;
        logic [SEQ_BITS-1:0]    s;
        logic [HANDLE_BITS-1:0] h;
    } entry_t;

    function automatic logic first(entry_t a, entry_t b);
        logic [TIME_BITS-1:0] d;
        d = b.t - a.t;
        if (d == '0)
        begin
            return a.s < b.s;
        end
        return d < HALF;
    endfunction

    logic [6:0]             cap_reg;
    logic [CW-1:0]          count_reg;
    logic [SEQ_BITS-1:0]    seq_reg;
    logic [1:0]             op_reg;
    logic [5:0]             idx_reg;
    logic [CW-1:0]          ptr_reg;
    entry_t                 mov_reg, left_reg, right_reg, par_reg;
    logic                   right_ok_reg;
    logic [HANDLE_BITS-1:0] hres_reg;
    logic [TIME_BITS-1:0]   tres_reg;
    logic [HANDLE_BITS-1:0] root_peek_reg;
    logic                   pushed_reg, popped_reg;
    logic [1:0]             st_code;

    logic [CW-1:0]  limit;
    logic [CW:0]    left_idx;
    logic [CW-1:0]  parent_idx;
    logic           go_left;
    entry_t         pick;
    logic [CW-1:0]  pick_idx;
    logic           we;
    logic [AW-1:0]  waddr, raddr;
    entry_t         wdata, rdata;
    logic [EW-1:0]  rdata_raw;

    assign limit      = (cap_reg > 7'(DEPTH)) ? CW'(DEPTH) : CW'(cap_reg);
    assign left_idx   = {ptr_reg, 1'b1};
    assign parent_idx = (ptr_reg - CW'(1)) >> 1;
    assign go_left    = !right_ok_reg || first(left_reg, right_reg);
    assign pick       = go_left ? left_reg : right_reg;
    assign pick_idx   = go_left ? left_idx[CW-1:0] : CW'(left_idx + (CW+1)'(1));

    // Memory write select
    always_comb
    begin
        we    = cmd.wr_moving | cmd.wr_pick | cmd.wr_parent;
        waddr = ptr_reg[AW-1:0];
        wdata = mov_reg;
        if (cmd.wr_pick)
        begin
            wdata = pick;
        end
        else if (cmd.wr_parent)
        begin
            wdata = par_reg;
        end
    end

    // Memory read select
    always_comb
    begin
        raddr = ptr_reg[AW-1:0];
        if (cmd.rd_left)
        begin
            raddr = left_idx[AW-1:0];
        end
        else if (cmd.rd_right)
        begin
            raddr = AW'(left_idx + (CW+1)'(1));
        end
        else if (cmd.rd_parent)
        begin
            raddr = parent_idx[AW-1:0];
        end
        else if (cmd.rd_slot && op_reg == wthq_pkg::OP_GET)
        begin
            raddr = idx_reg[AW-1:0];
        end
        else if (cmd.rd_slot && op_reg == wthq_pkg::OP_PEEK)
        begin
            raddr = '0;
        end
        else if (cmd.rd_slot && op_reg == wthq_pkg::OP_POP)
        begin
            raddr = AW'(count_reg - CW'(1));
        end
    end

    wthq_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata_raw)
    );
    assign rdata = rdata_raw;

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg   <= 7'd64;
            count_reg <= '0;
            seq_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.push_setup)
            begin
                count_reg <= count_reg + CW'(1);
                seq_reg   <= seq_reg + SEQ_BITS'(1);
            end
            else if (cmd.pop_setup)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg    <= in_op;
            idx_reg   <= in_index;
            mov_reg.t <= in_time;
            mov_reg.s <= seq_reg;
            mov_reg.h <= in_handle;
            hres_reg  <= '0;
            tres_reg  <= '0;
        end
        if (cmd.push_setup)
        begin
            ptr_reg <= count_reg;
        end
        // take the root handle before the walk overwrites the root
        if (cmd.pop_setup)
        begin
            ptr_reg  <= count_reg - CW'(1);
            hres_reg <= root_peek_reg;
        end
        if (cmd.root_ptr)
        begin
            ptr_reg <= '0;
        end
        if (cmd.cap_slot)
        begin
            mov_reg <= rdata;
        end
        if (cmd.cap_left)
        begin
            left_reg     <= rdata;
            right_ok_reg <= 1'b0;
        end
        if (cmd.cap_right)
        begin
            right_reg    <= rdata;
            right_ok_reg <= 1'b1;
        end
        if (cmd.wr_pick)
        begin
            ptr_reg <= pick_idx;
        end
        if (cmd.cap_parent)
        begin
            par_reg <= rdata;
        end
        if (cmd.wr_parent)
        begin
            ptr_reg <= parent_idx;
        end
        if (cmd.cap_result)
        begin
            if (op_reg == wthq_pkg::OP_PEEK)
            begin
                tres_reg <= rdata.t;
            end
            else
            begin
                hres_reg <= rdata.h;
            end
        end
        if (cmd.out_load)
        begin
            out_status <= st_code;
            out_handle <= hres_reg;
            out_time   <= tres_reg;
            out_count  <= count_reg;
        end
    end

    // The root handle stays readable in a shadow copy kept on every root write
    always_ff @(posedge clk)
    begin
        if (we && waddr == '0)
        begin
            root_peek_reg <= wdata.h;
        end
    end

    // Error status for the operation
    always_comb
    begin
        st_code = wthq_pkg::ST_OK;
        unique case (op_reg)
            wthq_pkg::OP_PUSH: if (stat.full && !pushed_reg) st_code = wthq_pkg::ST_OVERFLOW;
            wthq_pkg::OP_POP:  if (!popped_reg && stat.empty) st_code = wthq_pkg::ST_EMPTY;
            wthq_pkg::OP_PEEK: if (stat.empty) st_code = wthq_pkg::ST_EMPTY;
            wthq_pkg::OP_GET:  if (stat.bad_index) st_code = wthq_pkg::ST_BADINDEX;
            default:           st_code = wthq_pkg::ST_OK;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            pushed_reg <= 1'b0;
            popped_reg <= 1'b0;
        end
        if (cmd.push_setup)
        begin
            pushed_reg <= 1'b1;
        end
        if (cmd.pop_setup)
        begin
            popped_reg <= 1'b1;
        end
    end

    // Status toward the controller
    always_comb
    begin
        stat.op           = wthq_pkg::op_t'(op_reg);
        stat.full         = count_reg >= limit;
        stat.empty        = count_reg == '0;
        stat.bad_index    = {1'b0, idx_reg} >= 7'(count_reg);
        stat.has_left     = left_idx < (CW+1)'(count_reg);
        stat.has_right    = (left_idx + (CW+1)'(1)) < (CW+1)'(count_reg);
        stat.at_top       = ptr_reg == '0;
        stat.moving_first = first(mov_reg, par_reg);
        stat.last_gone    = count_reg == '0;
    end

endmodule
`default_nettype wire

[bench/wthq_checker.sv]
`timescale 1ns / 1ps
module wthq_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [71:0] s_axis_tdata,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [71:0] m_axis_tdata,
    input  wire logic        cfg_valid,
    input  wire logic        cfg_ready,
    input  wire logic [6:0]  cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [6:0]          occ;
        logic [29:0]         tick;
        logic [31:0]         handle;
        wthq_pkg::status_t   status;
    } reply_t;

    typedef struct {
        logic [29:0] tick;
        logic [31:0] seq;
        logic [31:0] handle;
    } timer_t;

    timer_t      heap_q[64];
    int          heap_n;
    logic [31:0] seq_next;
    logic [6:0]  cap_reg;
    reply_t      replies_due[$];

    // True when a fires no later than b in wrapped time
    function automatic bit fires_first(timer_t a, timer_t b);
        logic [29:0] d;
        d = b.tick - a.tick;
        if (d == 0)
            return a.seq < b.seq;
        return d < 30'h2000_0000;
    endfunction

    // Sift the entry at pos toward top
    function automatic void sift_up(int top, int pos);
        timer_t e;
        int     up;
        e = heap_q[pos];
        while (pos > top)
        begin
            up = (pos - 1) >> 1;
            if (!fires_first(e, heap_q[up]))
                break;
            heap_q[pos] = heap_q[up];
            pos = up;
        end
        heap_q[pos] = e;
    endfunction

    // Walk the root entry to a leaf, then sift it back up
    function automatic void sink_root();
        timer_t e;
        int     pos;
        int     c;
        pos = 0;
        e = heap_q[0];
        c = 1;
        while (c < heap_n)
        begin
            if (c + 1 < heap_n && !fires_first(heap_q[c], heap_q[c + 1]))
                c = c + 1;
            heap_q[pos] = heap_q[c];
            pos = c;
            c = 2 * pos + 1;
        end
        heap_q[pos] = e;
        sift_up(0, pos);
    endfunction

    function automatic reply_t apply_timer_op(logic [71:0] d);
        reply_t r;
        int     lim;
        int     idx;
        timer_t e;
        r = '0;
        r.status = wthq_pkg::ST_OK;
        lim = (cap_reg > 7'd64) ? 64 : int'(cap_reg);
        case (wthq_pkg::op_t'(d[1:0]))
            wthq_pkg::OP_PUSH:
            begin
                if (heap_n >= lim)
                    r.status = wthq_pkg::ST_OVERFLOW;
                else
                begin
                    e.tick = d[31:2];
                    e.seq = seq_next;
                    e.handle = d[63:32];
                    seq_next = seq_next + 32'd1;
                    heap_q[heap_n] = e;
                    sift_up(0, heap_n);
                    heap_n++;
                end
            end
            wthq_pkg::OP_POP:
            begin
                if (heap_n == 0)
                    r.status = wthq_pkg::ST_EMPTY;
                else
                begin
                    r.handle = heap_q[0].handle;
                    heap_n--;
                    heap_q[0] = heap_q[heap_n];
                    if (heap_n != 0)
                        sink_root();
                end
            end
            wthq_pkg::OP_PEEK:
            begin
                if (heap_n == 0)
                    r.status = wthq_pkg::ST_EMPTY;
                else
                    r.tick = heap_q[0].tick;
            end
            default:
            begin
                idx = int'(d[69:64]);
                if (idx >= heap_n)
                    r.status = wthq_pkg::ST_BADINDEX;
                else
                    r.handle = heap_q[idx].handle;
            end
        endcase
        r.occ = heap_n[6:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        fail_count++;
    endtask

    // Track accepted items and compare results
    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
        begin
            heap_n = 0;
            seq_next = '0;
            cap_reg = 7'd64;
            replies_due.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cap_reg = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(apply_timer_op(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata[70:0];
                if (replies_due.size() == 0)
                    report_mismatch("unexpected result", got.handle, 32'd0);
                else
                begin
                    want = replies_due.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.handle != want.handle)
                        report_mismatch("handle_out", got.handle, want.handle);
                    if (got.tick != want.tick)
                        report_mismatch("time_out", 32'(got.tick), 32'(want.tick));
                    if (got.occ != want.occ)
                        report_mismatch("occupancy", 32'(got.occ), 32'(want.occ));
                end
            end
            pending = replies_due.size();
        end
    end

endmodule

[bench/wraparound_timer_heap_queue_unit_test.sv]
`timescale 1ns / 1ps
module wraparound_timer_heap_queue_unit_test;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [6:0]  cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle;
    int          recv_stall;
    int          live;

    wraparound_timer_heap_queue_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    wthq_checker timer_checker (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Stall the result side at the current rate
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Send one item, idling first at the current rate; drop valid after accept
    task automatic send_item(wthq_pkg::op_t op, logic [29:0] tick, logic [31:0] handle,
                             logic [5:0] idx);
        while ($urandom_range(99) < send_idle)
            @(posedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b00, idx, handle, tick, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_capacity(logic [6:0] value);
        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random operation, deadlines mostly near a moving base time, so that wrapped ties happen
    task automatic random_item(int push_bias, logic [29:0] base);
        int          pick;
        logic [29:0] tick;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0: tick = 30'($urandom);
            default: tick = base + 30'($urandom_range(15));
        endcase
        if (pick < push_bias)
            send_item(wthq_pkg::OP_PUSH, tick, $urandom, 6'($urandom));
        else if (pick < push_bias + 25)
            send_item(wthq_pkg::OP_POP, 30'($urandom), $urandom, 6'($urandom));
        else if (pick < push_bias + 35)
            send_item(wthq_pkg::OP_PEEK, 30'($urandom), $urandom, 6'($urandom));
        else
            send_item(wthq_pkg::OP_GET, 30'($urandom), $urandom,
                      6'((live > 0 && pick[0]) ? $urandom_range(live - 1) : $urandom));
    endtask

    initial
    begin
        int          ph;
        logic [29:0] base;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        send_idle = 0;
        recv_stall = 0;
        live = 64;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty errors, wrap order, ties, extremes, bad index
        send_item(wthq_pkg::OP_POP, '0, '0, '0);
        send_item(wthq_pkg::OP_PEEK, '0, '0, '0);
        send_item(wthq_pkg::OP_GET, '0, '0, '0);
        send_item(wthq_pkg::OP_PUSH, 30'h3FFF_FFFF, 32'hFFFF_FFFF, 6'h3F);
        send_item(wthq_pkg::OP_PUSH, 30'h0000_0002, 32'h0000_0001, '0);
        send_item(wthq_pkg::OP_PUSH, 30'h3FFF_FFFF, 32'h0000_0002, '0);
        send_item(wthq_pkg::OP_PUSH, 30'h1FFF_FFFF, 32'h0000_0003, '0);
        send_item(wthq_pkg::OP_PUSH, 30'h2000_0000, 32'h0000_0004, '0);
        send_item(wthq_pkg::OP_PEEK, '0, '0, '0);
        send_item(wthq_pkg::OP_GET, '0, '0, 6'd4);
        send_item(wthq_pkg::OP_GET, '0, '0, 6'd5);
        send_item(wthq_pkg::OP_GET, '0, '0, 6'h3F);
        repeat (6) send_item(wthq_pkg::OP_POP, '0, '0, '0);
        write_capacity(7'd2);
        repeat (3) send_item(wthq_pkg::OP_PUSH, 30'd7, $urandom, '0);
        write_capacity(7'd0);
        send_item(wthq_pkg::OP_PUSH, 30'd1, 32'd9, '0);
        send_item(wthq_pkg::OP_PEEK, '0, '0, '0);
        repeat (2) send_item(wthq_pkg::OP_POP, '0, '0, '0);
        write_capacity(7'd127);

        // Random phases with varying idling and capacity
        base = 30'($urandom);
        for (ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 81; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 81; end
                default: begin send_idle = 6; recv_stall = 6; end
            endcase
            case (ph)
                3: begin write_capacity(7'd64); live = 64; end
                5: begin write_capacity(7'd65); live = 64; end
                6: begin write_capacity(7'($urandom_range(1, 63))); live = 20; end
                7: begin write_capacity(7'd64); live = 64; end
                default: ;
            endcase
            repeat (140)
            begin
                random_item((ph % 2) ? 70 : 45, base);
                base = base + 30'($urandom_range(3));
            end
        end

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("[wraparound_timer_heap_queue_unit] OK");
        else
            $display("[wraparound_timer_heap_queue_unit] ERROR");
        $finish;
    end

    initial
    begin
        #40_000_000;
        $display("[wraparound_timer_heap_queue_unit] ERROR");
        $finish;
    end

endmodule

[sim.f]
src/wthq_pkg.sv
src/wthq_ram.sv
src/wthq_ctrl.sv
src/wthq_dp.sv
src/wraparound_timer_heap_queue_unit.sv
bench/wthq_checker.sv
bench/wraparound_timer_heap_queue_unit_test.sv
